FILE: rtl/bounded_list_store_unit_defines.svh
// Assertion macros used by the property module of the list store.
`ifndef BOUNDED_LIST_STORE_UNIT_DEFINES_SVH
`define BOUNDED_LIST_STORE_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BLS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BLS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bls_pkg.sv
// Shared constants, codes and types of the bounded list store.
package bls_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [ADDR_W:0] DEPTH_EXT = (ADDR_W + 1)'(DEPTH);

    // Operation codes
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_REMOVE     = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RD_FRONT,
        S_RD_BACK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

    // Circular buffer address: base plus offset, wrapped at the depth
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

FILE: rtl/bls_mem.sv
// Entry storage: one write port, one read port with registered read data.
module bls_mem (
    input  logic                          clk,
    input  bls_pkg::mem_req_t             req,
    output logic [bls_pkg::DATA_WIDTH-1:0] rdata
);
    import bls_pkg::*;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

FILE: rtl/bounded_list_store_unit.sv
// Top level of the bounded list store: sequencer around the entry memory.
//
// A double-ended list of up to DEPTH values kept as a circular buffer in
// one synchronous memory. A transaction is taken when start is high and
// busy is low; action selects push front, push back, pop front, pop back
// or remove the first entry equal to value. Every transaction gives one
// result, shown on status, count, front_value and back_value for exactly
// one cycle while done is high; the receiver cannot stall it.
// Sequence, set by the single memory read port:
//   push, pop, failed operation, no-op: the front entry is read, then the
//   back entry (skipped when the list is empty after the operation); done
//   rises in the same cycle as busy falls.
//   remove on a nonempty list: each entry up to the match is read and
//   compared, each entry behind it is read and moved down into the hole,
//   then the ends are read back as for the other operations.
// After an operation that leaves entries, the front and back entries are
// read back from the memory, which sets the fixed part of the latency.
// Reset empties the list at once; the memory contents need no clearing.
module bounded_list_store_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     action,
    input  logic [bls_pkg::DATA_WIDTH-1:0] value,
    output logic                           done,
    output logic [1:0]                     status,
    output logic [bls_pkg::CNT_W-1:0]      count,
    output logic [bls_pkg::DATA_WIDTH-1:0] front_value,
    output logic [bls_pkg::DATA_WIDTH-1:0] back_value
);
    import bls_pkg::*;

    state_t                state_reg,  state_next;
    logic [ADDR_W-1:0]     head_reg,   head_next;
    logic [CNT_W-1:0]      count_reg,  count_next;
    logic [ADDR_W-1:0]     idx_reg,    idx_next;
    logic [1:0]            status_reg, status_next;
    logic                  done_reg,   done_next;
    logic [DATA_WIDTH-1:0] val_reg,    val_next;
    logic [DATA_WIDTH-1:0] front_reg,  front_next;
    logic [DATA_WIDTH-1:0] back_reg,   back_next;

    mem_req_t              mem_req;
    logic [DATA_WIDTH-1:0] rdata;

    logic                  is_full;
    logic                  is_empty;
    logic [ADDR_W-1:0]     head_dec;
    logic [ADDR_W-1:0]     idx_inc;
    logic                  idx_last;
    logic                  match;

    bls_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // Shared status terms
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : ADDR_W'(head_reg - 1'b1);
    assign idx_inc  = ADDR_W'(idx_reg + 1'b1);
    assign idx_last = ((CNT_W'({1'b0, idx_reg}) + CNT_W'(1)) == count_reg);
    assign match    = (rdata == val_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_REMOVE && !is_empty)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        state_next = S_RD_FRONT;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (match)
                begin
                    state_next = S_SHIFT_RD;
                end
                else if (idx_last)
                begin
                    state_next = S_RD_FRONT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = idx_last ? S_RD_FRONT : S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                state_next = S_SHIFT_RD;
            end
            S_RD_FRONT:
            begin
                state_next = is_empty ? S_IDLE : S_RD_BACK;
            end
            S_RD_BACK:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        done_next     = 1'b0;
        val_next      = val_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = head_reg;
        mem_req.wdata = val_reg;
        mem_req.raddr = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    val_next    = value;
                    status_next = ST_OK;
                    idx_next    = '0;
                    unique case (action)
                        ACT_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = head_dec;
                                mem_req.wdata = value;
                                head_next     = head_dec;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = wrap_add(head_reg, count_reg[ADDR_W-1:0]);
                                mem_req.wdata = value;
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = wrap_add(head_reg, ADDR_W'(1));
                                count_next = count_reg - 1'b1;
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                mem_req.raddr = wrap_add(head_reg, idx_reg);
            end
            S_SCAN_CMP:
            begin
                // hold idx on a match: it marks the hole to close
                if (!match)
                begin
                    if (idx_last)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                if (idx_last)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    mem_req.raddr = wrap_add(head_reg, idx_inc);
                end
            end
            S_SHIFT_WR:
            begin
                // move the next entry down into the hole
                mem_req.we    = 1'b1;
                mem_req.waddr = wrap_add(head_reg, idx_reg);
                mem_req.wdata = rdata;
                idx_next      = idx_inc;
            end
            S_RD_FRONT:
            begin
                mem_req.raddr = head_reg;
                if (is_empty)
                begin
                    front_next = '0;
                    back_next  = '0;
                    done_next  = 1'b1;
                end
            end
            S_RD_BACK:
            begin
                mem_req.raddr = wrap_add(head_reg, ADDR_W'(count_reg - 1'b1));
                front_next    = rdata;
            end
            S_FINISH:
            begin
                back_next = rdata;
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= ST_OK;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        front_reg <= front_next;
        back_reg  <= back_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign count       = count_reg;
    assign front_value = front_reg;
    assign back_value  = back_reg;

endmodule

FILE: rtl/bls_props.sv
// Port-level properties of the bounded list store and their binding.
`include "bounded_list_store_unit_defines.svh"

module bls_props (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic [1:0]                     status,
    input logic [bls_pkg::CNT_W-1:0]      count,
    input logic [bls_pkg::DATA_WIDTH-1:0] front_value,
    input logic [bls_pkg::DATA_WIDTH-1:0] back_value
);
    import bls_pkg::*;

    // Accepted transaction occupies the block
    `BLS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy low after accepted transaction")
    // Results never come back to back
    `BLS_ASSERT_NXT(a_done_gap, done, !done, "result strobe held for two cycles")
    // Empty list reports zero ends
    `BLS_ASSERT_IMP(a_empty_zero, done && count == '0, front_value == '0 && back_value == '0, "nonzero ends on empty list")
    // Full status only when the list is full
    `BLS_ASSERT_IMP(a_full_count, done && status == ST_FULL, count == CNT_W'(DEPTH), "full status with list not full")
    // Empty status only when the list is empty
    `BLS_ASSERT_IMP(a_empty_count, done && status == ST_EMPTY, count == '0, "empty status with entries present")

endmodule

bind bounded_list_store_unit bls_props u_bls_props (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .count       (count),
    .front_value (front_value),
    .back_value  (back_value)
);

FILE: verif/tb.sv
// Self-checking testbench for the bounded list store: directed and random operations.
`timescale 1ns / 1ps

module tb;

    import bls_pkg::*;

    // Spare action codes that the block treats as a no-op
    localparam logic [2:0] ACT_NOP_FIRST = 3'd5;
    localparam logic [2:0] ACT_NOP_LAST  = 3'd7;

    localparam int DRAIN_CYCLES = 2 * DEPTH + 10;

    typedef struct {
        logic [1:0]            status;
        logic [CNT_W-1:0]      count;
        logic [DATA_WIDTH-1:0] front;
        logic [DATA_WIDTH-1:0] back;
    } list_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [2:0]            action = '0;
    logic [DATA_WIDTH-1:0] value = '0;
    logic                  busy;
    logic                  done;
    logic [1:0]            status;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] back_value;

    // Shadow copy of the list contents, front at index 0
    logic [DATA_WIDTH-1:0] shadow_list[$];
    list_result_t          pending_results[$];

    // Small pool so that duplicates and removal hits are frequent
    logic [DATA_WIDTH-1:0] value_pool [8] = '{
        32'h0000_0001, 32'h0000_0002, 32'h8000_0000, 32'h7FFF_FFFF,
        32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0000_FFFF, 32'hFFFF_0000
    };

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int full_hits     = 0;
    int empty_hits    = 0;
    int miss_hits     = 0;
    int removes_ok    = 0;
    int deepest       = 0;
    int sender_idle_pct = 0;

    bounded_list_store_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .done        (done),
        .status      (status),
        .count       (count),
        .front_value (front_value),
        .back_value  (back_value)
    );

    always #5 clk = ~clk;

    // Apply one operation to the shadow list and return the expected result
    function automatic list_result_t apply_list_op(input logic [2:0] op,
                                                   input logic [DATA_WIDTH-1:0] val);
        list_result_t res;
        int           idx;
        int           i;
        res.status = ST_OK;
        case (op)
            ACT_PUSH_FRONT, ACT_PUSH_BACK:
            begin
                if (shadow_list.size() >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else if (op == ACT_PUSH_FRONT)
                begin
                    shadow_list.push_front(val);
                end
                else
                begin
                    shadow_list.push_back(val);
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK:
            begin
                if (shadow_list.size() == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else if (op == ACT_POP_FRONT)
                begin
                    void'(shadow_list.pop_front());
                end
                else
                begin
                    void'(shadow_list.pop_back());
                end
            end
            ACT_REMOVE:
            begin
                if (shadow_list.size() == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    idx = -1;
                    for (i = 0; i < shadow_list.size() && idx < 0; i++)
                    begin
                        if (shadow_list[i] == val)
                        begin
                            idx = i;
                        end
                    end
                    if (idx < 0)
                    begin
                        res.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        shadow_list.delete(idx);
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.count = CNT_W'(shadow_list.size());
        if (shadow_list.size() == 0)
        begin
            res.front = '0;
            res.back  = '0;
        end
        else
        begin
            res.front = shadow_list[0];
            res.back  = shadow_list[shadow_list.size() - 1];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_WIDTH-1:0] got,
                                   input logic [DATA_WIDTH-1:0] want);
        $display("%0t: result %0d: %s got %h, expected %h", $realtime, results_seen,
                 field, got, want);
        error_count++;
    endtask

    // Drive one transaction and hold it until the block takes it
    task automatic send_item(input logic [2:0] op, input logic [DATA_WIDTH-1:0] val);
        list_result_t res;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start  <= 1'b1;
        action <= op;
        value  <= val;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        res = apply_list_op(op, val);
        pending_results.push_back(res);
        items_sent++;
        case (res.status)
            ST_FULL:      full_hits++;
            ST_EMPTY:     empty_hits++;
            ST_NOT_FOUND: miss_hits++;
            default:      if (op == ACT_REMOVE) removes_ok++;
        endcase
        if (shadow_list.size() > deepest)
        begin
            deepest = shadow_list.size();
        end
    endtask

    // Drop start and hold off until every expected result has arrived
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [DATA_WIDTH-1:0] pool_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return '0;
        end
        else if (r < 20)
        begin
            return '1;
        end
        else if (r < 60)
        begin
            return value_pool[$urandom_range(7)];
        end
        return $urandom();
    endfunction

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin : check_result
        list_result_t want;
        if (rst_n && done === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected done", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    report_mismatch("status", DATA_WIDTH'(status), DATA_WIDTH'(want.status));
                end
                if (count !== want.count)
                begin
                    report_mismatch("count", DATA_WIDTH'(count), DATA_WIDTH'(want.count));
                end
                if (front_value !== want.front)
                begin
                    report_mismatch("front_value", front_value, want.front);
                end
                if (back_value !== want.back)
                begin
                    report_mismatch("back_value", back_value, want.back);
                end
            end
        end
    end

    // Both pops, a removal and two of the spare codes on an empty list
    task automatic test_empty_list();
        send_item(ACT_POP_FRONT, '0);
        send_item(ACT_POP_BACK, '1);
        send_item(ACT_REMOVE, '0);
        send_item(ACT_NOP_FIRST, 32'h1234_5678);
        send_item(ACT_NOP_LAST, '1);
    endtask

    // Removal that hits the front entry, then a removal that misses
    task automatic test_front_match();
        send_item(ACT_PUSH_FRONT, '0);
        send_item(ACT_PUSH_BACK, '1);
        send_item(ACT_REMOVE, '0);
        send_item(ACT_REMOVE, 32'h0BAD_F00D);
    endtask

    // Fill to capacity with duplicates, then push into the full list
    task automatic test_full_list();
        int i;
        for (i = 0; i < DEPTH - 1; i++)
        begin
            if (i % 2 == 0)
            begin
                send_item(ACT_PUSH_FRONT, value_pool[i % 5]);
            end
            else
            begin
                send_item(ACT_PUSH_BACK, value_pool[i % 5]);
            end
        end
        send_item(ACT_PUSH_FRONT, 32'hDEAD_BEEF);
        send_item(ACT_PUSH_BACK, 32'hDEAD_BEEF);
        drain_results();
    endtask

    // Random operations, drifting between filling and draining the list
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int               n;
        int               r;
        int               run_left;
        bit               fill_bias;
        logic [2:0]       op;
        logic [DATA_WIDTH-1:0] val;
        sender_idle_pct = idle_pct;
        fill_bias = 1'($urandom_range(1));
        run_left  = $urandom_range(60, 20);
        for (n = 0; n < n_items; n++)
        begin
            if (run_left == 0)
            begin
                fill_bias = !fill_bias;
                run_left  = $urandom_range(60, 20);
            end
            run_left--;
            r = $urandom_range(99);
            if (r < 5)
            begin
                op = 3'($urandom_range(ACT_NOP_LAST, ACT_NOP_FIRST));
            end
            else if (r < 20)
            begin
                op = ACT_REMOVE;
            end
            else if ((fill_bias && r < 70) || (!fill_bias && r < 40))
            begin
                op = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
            end
            else
            begin
                op = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
            end
            // Most removals name a value that is in the list
            if (op == ACT_REMOVE && shadow_list.size() != 0 && $urandom_range(99) < 70)
            begin
                val = shadow_list[$urandom_range(shadow_list.size() - 1)];
            end
            else
            begin
                val = pool_value();
            end
            send_item(op, val);
        end
        drain_results();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_front_match();
        test_full_list();
        test_random_traffic(384, 22);
        test_random_traffic(384, 48);
        test_random_traffic(384, 0);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operations, checked %0d results, list reached depth %0d.",
                 items_sent, results_seen, deepest);
        $display("Full inserts %0d, empty-list ops %0d, removal hits %0d, misses %0d.",
                 full_hits, empty_hits, removes_ok, miss_hits);
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d mismatches found", error_count);
            $display("TB_ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bls_pkg.sv
rtl/bls_mem.sv
rtl/bounded_list_store_unit.sv
rtl/bls_props.sv
verif/tb.sv
